/* src/assert_macros.svh */
// Assertion macros for the checker file of the project.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked on every rising edge outside reset.
`define RRPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked on every rising edge, reset included.
`define RRPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rrpm_pkg.sv */
// Shared types, codes and default sizes of the rectangle region pixel mask.
// Depends on nothing; every other file of the block but assert_macros.svh uses it.
package rrpm_pkg;

  localparam int MAX_REGIONS_DEF = 8;
  localparam int MAX_DIM_DEF     = 4096;

  localparam int CFG_DIM_W   = 13;
  localparam int PIX_W       = 8;
  localparam int COORD_IN_W  = 14;
  localparam int COORD_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_CLEAR = 2'd0;
  localparam opcode_t OP_LOAD  = 2'd1;
  localparam opcode_t OP_PIXEL = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_SIZE = 2'd1;
  localparam status_t ST_MISS     = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH  = 2'd0;
  localparam reg_idx_t REG_HEIGHT = 2'd1;
  localparam reg_idx_t REG_BG     = 2'd2;

  typedef struct packed {
    logic                      clear;
    logic                      load;
    logic                      exclude;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
  } tbl_cmd_t;

  typedef struct packed {
    logic hit_inc;
    logic hit_exc;
    logic no_inc;
    logic full;
  } tbl_stat_t;

endpackage

/* src/rrpm_table.sv */
// Region table of the pixel mask: stored rectangles, counts and parallel hit test.
// Depends on rrpm_pkg.
module rrpm_table #(
  parameter int MAX_REGIONS = rrpm_pkg::MAX_REGIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rrpm_pkg::tbl_cmd_t                 cmd,
  input  logic signed [rrpm_pkg::COORD_W-1:0] col,
  input  logic signed [rrpm_pkg::COORD_W-1:0] row,
  output rrpm_pkg::tbl_stat_t                stat
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  typedef struct packed {
    logic                                exclude;
    logic signed [rrpm_pkg::COORD_W-1:0] x0;
    logic signed [rrpm_pkg::COORD_W-1:0] x1;
    logic signed [rrpm_pkg::COORD_W-1:0] y0;
    logic signed [rrpm_pkg::COORD_W-1:0] y1;
  } entry_t;

  entry_t             tbl_r [MAX_REGIONS];
  logic [CNT_W-1:0]   region_cnt_r, region_cnt_nxt;
  logic [CNT_W-1:0]   incl_cnt_r, incl_cnt_nxt;
  logic               full;
  logic               do_load;
  logic               hit_inc, hit_exc;

  assign full    = region_cnt_r >= CNT_W'(MAX_REGIONS);
  assign do_load = cmd.load && !full;

  always_comb begin
    region_cnt_nxt = region_cnt_r;
    incl_cnt_nxt   = incl_cnt_r;
    if (cmd.clear) begin
      region_cnt_nxt = '0;
      incl_cnt_nxt   = '0;
    end else if (do_load) begin
      region_cnt_nxt = region_cnt_r + CNT_W'(1);
      if (!cmd.exclude) begin
        incl_cnt_nxt = incl_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_cnt_r <= '0;
      incl_cnt_r   <= '0;
    end else begin
      region_cnt_r <= region_cnt_nxt;
      incl_cnt_r   <= incl_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (do_load && region_cnt_r == CNT_W'(i)) begin
        tbl_r[i] <= '{exclude: cmd.exclude, x0: cmd.x0, x1: cmd.x1, y0: cmd.y0, y1: cmd.y1};
      end
    end
  end

  always_comb begin
    hit_inc = 1'b0;
    hit_exc = 1'b0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      if (CNT_W'(i) < region_cnt_r && col >= tbl_r[i].x0 && col < tbl_r[i].x1 &&
          row >= tbl_r[i].y0 && row < tbl_r[i].y1) begin
        if (tbl_r[i].exclude) begin
          hit_exc = 1'b1;
        end else begin
          hit_inc = 1'b1;
        end
      end
    end
  end

  assign stat.hit_inc = hit_inc;
  assign stat.hit_exc = hit_exc;
  assign stat.no_inc  = incl_cnt_r == '0;
  assign stat.full    = full;

endmodule

/* src/rectangle_region_pixel_mask_top.sv */
// Top level of the rectangle region pixel mask: beat registers, position counters
// and configuration registers. Depends on rrpm_pkg and rrpm_table.
//
// The block takes one beat per clock unless the output stalls and returns one result
// beat per input beat: an input register feeds the load checks and the region compares,
// which run against all MAX_REGIONS table entries at once, and the result lands in an
// output register. While a result waits at the output the input register still takes
// one more beat. Configuration is to be written over the APB-style port only while no
// beat is in flight, not enforced by the block; there is no clearing pass after reset.
module rectangle_region_pixel_mask_top #(
  parameter int MAX_REGIONS = rrpm_pkg::MAX_REGIONS_DEF,
  parameter int MAX_DIM     = rrpm_pkg::MAX_DIM_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_opcode,
  input  logic                                  in_region_kind,
  input  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_x,
  input  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_y,
  input  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_width,
  input  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_height,
  input  logic [rrpm_pkg::PIX_W-1:0]            in_pixel_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rrpm_pkg::PIX_W-1:0]            out_pixel_out,
  output logic [rrpm_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_eligible,
  output logic                                  out_frame_end,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [rrpm_pkg::APB_ADDR_W-1:0]       cfg_paddr,
  input  logic [rrpm_pkg::APB_DATA_W-1:0]       cfg_pwdata,
  output logic [rrpm_pkg::APB_DATA_W-1:0]       cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int CW      = rrpm_pkg::COORD_W;
  localparam int CFG_W   = rrpm_pkg::CFG_DIM_W;

  // Configuration registers.
  logic [CFG_W-1:0]            width_r, height_r;
  logic [rrpm_pkg::PIX_W-1:0]  bg_r;
  logic                        cfg_wr;
  rrpm_pkg::reg_idx_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(4096);
      height_r <= CFG_W'(4096);
      bg_r     <= rrpm_pkg::PIX_W'(255);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rrpm_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[CFG_W-1:0];
        rrpm_pkg::REG_HEIGHT: height_r <= cfg_pwdata[CFG_W-1:0];
        rrpm_pkg::REG_BG:     bg_r     <= cfg_pwdata[rrpm_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rrpm_pkg::REG_WIDTH:  cfg_prdata = rrpm_pkg::APB_DATA_W'(width_r);
      rrpm_pkg::REG_HEIGHT: cfg_prdata = rrpm_pkg::APB_DATA_W'(height_r);
      rrpm_pkg::REG_BG:     cfg_prdata = rrpm_pkg::APB_DATA_W'(bg_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // Effective frame size, clamped to 1..MAX_DIM.
  logic [CFG_W:0]   wd_full, ht_full;
  logic [DIM_W-1:0] wd, ht;

  always_comb begin
    if (width_r == '0) begin
      wd_full = (CFG_W + 1)'(1);
    end else if ({1'b0, width_r} > (CFG_W + 1)'(MAX_DIM)) begin
      wd_full = (CFG_W + 1)'(MAX_DIM);
    end else begin
      wd_full = {1'b0, width_r};
    end
    if (height_r == '0) begin
      ht_full = (CFG_W + 1)'(1);
    end else if ({1'b0, height_r} > (CFG_W + 1)'(MAX_DIM)) begin
      ht_full = (CFG_W + 1)'(MAX_DIM);
    end else begin
      ht_full = {1'b0, height_r};
    end
  end

  assign wd = DIM_W'(wd_full);
  assign ht = DIM_W'(ht_full);

  // Input register.
  logic                                   s1_vld_r;
  rrpm_pkg::opcode_t                      s1_op_r;
  logic                                   s1_kind_r;
  logic signed [rrpm_pkg::COORD_IN_W-1:0] s1_x_r, s1_y_r, s1_w_r, s1_h_r;
  logic [rrpm_pkg::PIX_W-1:0]             s1_pix_r;
  logic                                   advance;

  assign advance  = s1_vld_r && (!out_valid || out_ready);
  assign in_ready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_opcode;
      s1_kind_r <= in_region_kind;
      s1_x_r    <= in_region_x;
      s1_y_r    <= in_region_y;
      s1_w_r    <= in_region_width;
      s1_h_r    <= in_region_height;
      s1_pix_r  <= in_pixel_value;
    end
  end

  // Load checks.
  logic signed [CW-1:0] x_s, y_s, w_s, h_s, x1_s, y1_s, wd_s, ht_s;
  logic                 is_clear, is_load, is_pixel;
  logic                 bad_size, miss;

  assign x_s  = CW'(s1_x_r);
  assign y_s  = CW'(s1_y_r);
  assign w_s  = CW'(s1_w_r);
  assign h_s  = CW'(s1_h_r);
  assign x1_s = x_s + w_s;
  assign y1_s = y_s + h_s;
  assign wd_s = CW'(wd);
  assign ht_s = CW'(ht);

  assign is_clear = s1_op_r == rrpm_pkg::OP_CLEAR;
  assign is_load  = s1_op_r == rrpm_pkg::OP_LOAD;
  assign is_pixel = s1_op_r == rrpm_pkg::OP_PIXEL;

  assign bad_size = w_s[CW-1] || (w_s == '0) || h_s[CW-1] || (h_s == '0);
  assign miss     = !((x_s < wd_s) && !x1_s[CW-1] && (x1_s != '0) &&
                      (y_s < ht_s) && !y1_s[CW-1] && (y1_s != '0));

  // Position counters.
  logic [POS_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic             col_last, row_last;

  assign col_last = (DIM_W'(col_r) + DIM_W'(1)) >= wd;
  assign row_last = (DIM_W'(row_r) + DIM_W'(1)) >= ht;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance && is_pixel) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + POS_W'(1);
      end else begin
        col_nxt = col_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Region table.
  rrpm_pkg::tbl_cmd_t  tbl_cmd;
  rrpm_pkg::tbl_stat_t tbl_stat;

  assign tbl_cmd.clear   = advance && is_clear;
  assign tbl_cmd.load    = advance && is_load && !bad_size && !miss;
  assign tbl_cmd.exclude = s1_kind_r;
  assign tbl_cmd.x0      = x_s;
  assign tbl_cmd.x1      = x1_s;
  assign tbl_cmd.y0      = y_s;
  assign tbl_cmd.y1      = y1_s;

  rrpm_table #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (tbl_cmd),
    .col  (CW'(col_r)),
    .row  (CW'(row_r)),
    .stat (tbl_stat)
  );

  // Result computation and output register.
  logic                        elig;
  rrpm_pkg::status_t           status_nxt;
  logic [rrpm_pkg::PIX_W-1:0]  pix_nxt;
  logic                        out_vld_r;
  logic [rrpm_pkg::PIX_W-1:0]  out_pix_r;
  rrpm_pkg::status_t           out_status_r;
  logic                        out_elig_r, out_fend_r;

  assign elig = is_pixel && (tbl_stat.no_inc || tbl_stat.hit_inc) && !tbl_stat.hit_exc;

  always_comb begin
    status_nxt = rrpm_pkg::ST_OK;
    if (is_load) begin
      if (bad_size) begin
        status_nxt = rrpm_pkg::ST_BAD_SIZE;
      end else if (miss) begin
        status_nxt = rrpm_pkg::ST_MISS;
      end else if (tbl_stat.full) begin
        status_nxt = rrpm_pkg::ST_FULL;
      end
    end
  end

  assign pix_nxt = !is_pixel ? '0 : (elig ? s1_pix_r : bg_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix_r    <= pix_nxt;
      out_status_r <= status_nxt;
      out_elig_r   <= elig;
      out_fend_r   <= is_pixel && col_last && row_last;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_pixel_out = out_pix_r;
  assign out_status    = out_status_r;
  assign out_eligible  = out_elig_r;
  assign out_frame_end = out_fend_r;

endmodule

/* src/rrpm_checker.sv */
// Port-level checker for the rectangle region pixel mask, bound to the top level.
// Depends on rrpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrpm_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [rrpm_pkg::PIX_W-1:0]            out_pixel_out,
  input logic [rrpm_pkg::STATUS_W-1:0]         out_status,
  input logic                                  out_eligible,
  input logic                                  out_frame_end
);

  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) &&
                                $stable(out_status) && $stable(out_eligible) &&
                                $stable(out_frame_end);
  endproperty

  property p_reject_zero;
    out_valid && out_status != rrpm_pkg::ST_OK |->
      out_pixel_out == '0 && !out_eligible && !out_frame_end;
  endproperty

  property p_pixel_ok;
    out_valid && (out_eligible || out_frame_end) |-> out_status == rrpm_pkg::ST_OK;
  endproperty

  // The input side only stalls behind a result beat that is itself stalled.
  property p_in_stall;
    in_valid && !in_ready |-> out_valid && !out_ready;
  endproperty

  property p_reset_idle;
    !rst_n |=> !out_valid;
  endproperty

  `RRPM_ASSERT(a_out_hold, clk, rst_n, p_out_hold, "result beat changed while stalled")
  `RRPM_ASSERT(a_reject_zero, clk, rst_n, p_reject_zero, "rejected load carries pixel data")
  `RRPM_ASSERT(a_pixel_ok, clk, rst_n, p_pixel_ok, "pixel beat with nonzero status")
  `RRPM_ASSERT(a_in_stall, clk, rst_n, p_in_stall, "input stalled with no stalled result")
  `RRPM_ASSERT_ALWAYS(a_reset_idle, clk, p_reset_idle, "result beat right after reset")

endmodule

bind rectangle_region_pixel_mask_top rrpm_checker u_rrpm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_pixel_out(out_pixel_out),
  .out_status   (out_status),
  .out_eligible (out_eligible),
  .out_frame_end(out_frame_end)
);

/* tb/sv/rectangle_region_pixel_mask_top_tb.sv */
// Self-checking testbench for rectangle_region_pixel_mask_top: random and directed beats
// are checked against an in-bench model of the region table and the raster counters.
// Depends on rrpm_pkg and the block's RTL.
`timescale 1ns / 1ps

module rectangle_region_pixel_mask_top_tb;

  localparam rrpm_pkg::opcode_t OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 200;

  typedef struct {
    rrpm_pkg::opcode_t                      opcode;
    logic                                   kind;
    logic signed [rrpm_pkg::COORD_IN_W-1:0] x;
    logic signed [rrpm_pkg::COORD_IN_W-1:0] y;
    logic signed [rrpm_pkg::COORD_IN_W-1:0] w;
    logic signed [rrpm_pkg::COORD_IN_W-1:0] h;
    logic [rrpm_pkg::PIX_W-1:0]             pixel;
  } beat_t;

  typedef struct {
    logic [rrpm_pkg::PIX_W-1:0] pixel;
    rrpm_pkg::status_t          status;
    logic                       eligible;
    logic                       frame_end;
  } mask_res_t;

  typedef struct {
    logic exclude;
    int   x;
    int   y;
    int   w;
    int   h;
  } rect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [1:0]                             in_opcode = '0;
  logic                                   in_region_kind = 1'b0;
  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_x = '0;
  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_y = '0;
  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_width = '0;
  logic signed [rrpm_pkg::COORD_IN_W-1:0] in_region_height = '0;
  logic [rrpm_pkg::PIX_W-1:0]             in_pixel_value = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [rrpm_pkg::PIX_W-1:0]             out_pixel_out;
  logic [rrpm_pkg::STATUS_W-1:0]          out_status;
  logic                                   out_eligible;
  logic                                   out_frame_end;
  logic                                   cfg_psel = 1'b0;
  logic                                   cfg_penable = 1'b0;
  logic                                   cfg_pwrite = 1'b0;
  logic [rrpm_pkg::APB_ADDR_W-1:0]        cfg_paddr = '0;
  logic [rrpm_pkg::APB_DATA_W-1:0]        cfg_pwdata = '0;
  logic [rrpm_pkg::APB_DATA_W-1:0]        cfg_prdata;
  logic                                   cfg_pready;

  beat_t     beats_pending[$];
  mask_res_t results_due[$];
  int        beats_queued = 0;
  int        beats_accepted = 0;
  int        mismatches = 0;
  logic      in_took = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_phase = 1'b0;
  int hold_count = 0;

  rect_t                      rect_tbl[rrpm_pkg::MAX_REGIONS_DEF];
  int                         n_rects = 0;
  int                         n_includes = 0;
  int                         col_pos = 0;
  int                         row_pos = 0;
  logic [12:0]                width_reg = 13'd4096;
  logic [12:0]                height_reg = 13'd4096;
  logic [rrpm_pkg::PIX_W-1:0] bg_reg = 8'd255;

  rectangle_region_pixel_mask_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_region_kind  (in_region_kind),
    .in_region_x     (in_region_x),
    .in_region_y     (in_region_y),
    .in_region_width (in_region_width),
    .in_region_height(in_region_height),
    .in_pixel_value  (in_pixel_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_out   (out_pixel_out),
    .out_status      (out_status),
    .out_eligible    (out_eligible),
    .out_frame_end   (out_frame_end),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [12:0] v);
    if (v == 13'd0) begin
      return 1;
    end
    if (int'(v) > rrpm_pkg::MAX_DIM_DEF) begin
      return rrpm_pkg::MAX_DIM_DEF;
    end
    return int'(v);
  endfunction

  // Updates the table and raster position for one beat and returns its result.
  function automatic mask_res_t apply_beat(beat_t b);
    mask_res_t r;
    int wd;
    int ht;
    int x;
    int y;
    int w;
    int h;
    logic hit_inc;
    logic hit_exc;
    r = '{default: '0};
    wd = clamp_dim(width_reg);
    ht = clamp_dim(height_reg);
    x = b.x;
    y = b.y;
    w = b.w;
    h = b.h;
    case (b.opcode)
      rrpm_pkg::OP_CLEAR: begin
        n_rects = 0;
        n_includes = 0;
      end
      rrpm_pkg::OP_LOAD: begin
        if (w <= 0 || h <= 0) begin
          r.status = rrpm_pkg::ST_BAD_SIZE;
        end else if (!(((x > 0) ? x : 0) < ((x + w < wd) ? x + w : wd) &&
                       ((y > 0) ? y : 0) < ((y + h < ht) ? y + h : ht))) begin
          r.status = rrpm_pkg::ST_MISS;
        end else if (n_rects >= rrpm_pkg::MAX_REGIONS_DEF) begin
          r.status = rrpm_pkg::ST_FULL;
        end else begin
          rect_tbl[n_rects] = '{exclude: b.kind, x: x, y: y, w: w, h: h};
          n_rects++;
          if (!b.kind) begin
            n_includes++;
          end
        end
      end
      rrpm_pkg::OP_PIXEL: begin
        hit_inc = (n_includes == 0);
        hit_exc = 1'b0;
        for (int i = 0; i < n_rects; i++) begin
          if (col_pos >= rect_tbl[i].x && col_pos < rect_tbl[i].x + rect_tbl[i].w &&
              row_pos >= rect_tbl[i].y && row_pos < rect_tbl[i].y + rect_tbl[i].h) begin
            if (rect_tbl[i].exclude) begin
              hit_exc = 1'b1;
            end else begin
              hit_inc = 1'b1;
            end
          end
        end
        r.eligible = hit_inc && !hit_exc;
        r.pixel = r.eligible ? b.pixel : bg_reg;
        if (col_pos >= wd - 1) begin
          col_pos = 0;
          if (row_pos >= ht - 1) begin
            r.frame_end = 1'b1;
            row_pos = 0;
          end else begin
            row_pos++;
          end
        end else begin
          col_pos++;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic beat_t noise_beat();
    beat_t b;
    b.opcode = rrpm_pkg::opcode_t'($urandom_range(3));
    b.kind = 1'($urandom_range(1));
    b.x = 14'($urandom);
    b.y = 14'($urandom);
    b.w = 14'($urandom);
    b.h = 14'($urandom);
    b.pixel = 8'($urandom);
    return b;
  endfunction

  function automatic beat_t load_beat(logic kind, int x, int y, int w, int h);
    beat_t b;
    b = noise_beat();
    b.opcode = rrpm_pkg::OP_LOAD;
    b.kind = kind;
    b.x = 14'(x);
    b.y = 14'(y);
    b.w = 14'(w);
    b.h = 14'(h);
    return b;
  endfunction

  function automatic beat_t op_beat(rrpm_pkg::opcode_t op);
    beat_t b;
    b = noise_beat();
    b.opcode = op;
    return b;
  endfunction

  function automatic void queue_beat(beat_t b);
    beats_pending.push_back(b);
    beats_queued++;
  endfunction

  // An optional clear, a handful of rectangles near the image and a frame of pixels
  // (at most 48, plus 0 to 2), stray beats mixed in. Returns the number of beats queued.
  function automatic int queue_roi_frame();
    int wd;
    int ht;
    int spx;
    int spy;
    int n;
    int pix;
    wd = clamp_dim(width_reg);
    ht = clamp_dim(height_reg);
    spx = (wd < 16) ? wd : 16;
    spy = (ht < 16) ? ht : 16;
    n = 0;
    if ($urandom_range(3) != 0) begin
      queue_beat(op_beat(rrpm_pkg::OP_CLEAR));
      n++;
    end
    repeat ($urandom_range(10)) begin
      queue_beat(load_beat(1'($urandom_range(1)), int'($urandom_range(spx + 2)) - 2,
                           int'($urandom_range(spy + 2)) - 2, int'($urandom_range(spx + 1, 1)),
                           int'($urandom_range(spy + 1, 1))));
      n++;
      if ($urandom_range(7) == 0) begin
        queue_beat(noise_beat());
        n++;
      end
    end
    pix = (wd * ht > 48) ? 48 : wd * ht;
    pix += $urandom_range(2);
    repeat (pix) begin
      queue_beat(op_beat(rrpm_pkg::OP_PIXEL));
      n++;
      if ($urandom_range(15) == 0) begin
        queue_beat(noise_beat());
        n++;
      end
    end
    return n;
  endfunction

  // Input beats: a new beat goes out only after the current one is taken.
  always @(negedge clk) begin : drive_beats
    beat_t b;
    if (rst_n && (!in_valid || in_took)) begin
      if (beats_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = beats_pending.pop_front();
        in_opcode <= b.opcode;
        in_region_kind <= b.kind;
        in_region_x <= b.x;
        in_region_y <= b.y;
        in_region_width <= b.w;
        in_region_height <= b.h;
        in_pixel_value <= b.pixel;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (hold_phase && hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
      out_ready <= 1'b0;
    end else begin
      if (!hold_phase) begin
        hold_count <= 0;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    beat_t     b;
    mask_res_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        b.opcode = in_opcode;
        b.kind = in_region_kind;
        b.x = in_region_x;
        b.y = in_region_y;
        b.w = in_region_width;
        b.h = in_region_height;
        b.pixel = in_pixel_value;
        results_due.push_back(apply_beat(b));
        beats_accepted++;
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no pending input beat");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", want.pixel, out_pixel_out);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_eligible !== want.eligible) begin
            $error("eligible: expected %0d, got %0d", want.eligible, out_eligible);
            mismatches++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (beats_accepted != beats_queued || results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic cfg_write(rrpm_pkg::reg_idx_t idx, logic [rrpm_pkg::APB_DATA_W-1:0] value);
    logic [rrpm_pkg::APB_DATA_W-1:0] rd;
    logic [rrpm_pkg::APB_DATA_W-1:0] stored;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    case (idx)
      rrpm_pkg::REG_WIDTH: begin
        width_reg = value[12:0];
        stored = 32'(value[12:0]);
      end
      rrpm_pkg::REG_HEIGHT: begin
        height_reg = value[12:0];
        stored = 32'(value[12:0]);
      end
      default: begin
        bg_reg = value[rrpm_pkg::PIX_W-1:0];
        stored = 32'(value[rrpm_pkg::PIX_W-1:0]);
      end
    endcase
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== stored) begin
      $error("register %0d: expected %0d, got %0d", idx, stored, rd);
      mismatches++;
    end
  endtask

  task automatic run_phase(logic [12:0] wd, logic [12:0] ht, logic [rrpm_pkg::PIX_W-1:0] bg,
                           int idle_pct, int stall_pct, bit hold);
    int n;
    cfg_write(rrpm_pkg::REG_WIDTH, 32'(wd));
    cfg_write(rrpm_pkg::REG_HEIGHT, 32'(ht));
    cfg_write(rrpm_pkg::REG_BG, 32'(bg));
    @(posedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hold_phase = hold;
    n = 0;
    while (n < PHASE_BEATS) begin
      n += queue_roi_frame();
    end
    wait_drained();
    @(posedge clk);
    hold_phase = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Default configuration, empty table.
    @(posedge clk);
    queue_beat(op_beat(rrpm_pkg::OP_PIXEL));
    queue_beat('{opcode: OP_UNUSED, kind: 1'b1, x: '1, y: '1, w: '1, h: '1, pixel: '1});
    queue_beat(op_beat(rrpm_pkg::OP_CLEAR));
    wait_drained();

    cfg_write(rrpm_pkg::REG_WIDTH, 32'd4);
    cfg_write(rrpm_pkg::REG_HEIGHT, 32'd3);
    cfg_write(rrpm_pkg::REG_BG, 32'd0);
    @(posedge clk);
    queue_beat(load_beat(1'b0, 0, 0, 0, 1));
    queue_beat(load_beat(1'b1, 0, 0, 1, -8192));
    queue_beat(load_beat(1'b0, -8192, -8192, 8191, 8191));
    queue_beat(load_beat(1'b1, 8191, 0, 1, 1));
    queue_beat(load_beat(1'b0, 4, 0, 1, 1));
    queue_beat(load_beat(1'b0, 1, 0, 2, 2));
    queue_beat(load_beat(1'b1, 2, 1, 8191, 1));
    for (int i = 0; i < 8; i++) begin
      queue_beat('{opcode: rrpm_pkg::OP_PIXEL, kind: 1'b0, x: '0, y: '0, w: '0, h: '0,
                   pixel: (i % 2 == 0) ? 8'hFF : 8'h01});
    end
    // Fill the table, then overflow it; a bad size still wins over a full table.
    for (int i = 0; i < 6; i++) begin
      queue_beat(load_beat(1'(i % 2), -1, -1, 8191, 2));
    end
    queue_beat(load_beat(1'b0, 0, 0, 1, 1));
    queue_beat(load_beat(1'b0, 0, 0, -1, 1));
    wait_drained();

    run_phase(13'd6, 13'd4, 8'h00, 0, 0, 1'b0);
    run_phase(13'd1, 13'd1, 8'hFF, 57, 0, 1'b0);
    run_phase(13'd0, 13'd5, 8'hA5, 0, 57, 1'b0);
    run_phase(13'd8191, 13'd1, 8'h5A, 28, 28, 1'b0);
    run_phase(13'd4096, 13'd8191, 8'hC3, 0, 0, 1'b1);
    run_phase(13'd4, 13'd2, 8'h81, 28, 28, 1'b0);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("rectangle_region_pixel_mask_top: match");
    end else begin
      $display("rectangle_region_pixel_mask_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rectangle_region_pixel_mask_top: mismatch");
    $finish;
  end

endmodule
